[hdl/slr_pkg.sv]
// Shared widths, codes, command and status types for the linear regression block.
`timescale 1ns / 1ps

package slr_pkg;

  localparam int MAX_SAMPLES = 4096;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 48;
  localparam int ST_W   = 2;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = CNT_W + IN_W;
  localparam int PRD_W  = 2 * IN_W;
  localparam int PSUM_W = CNT_W + PRD_W - 1;
  localparam int D_W    = CNT_W + PSUM_W + 1;

  localparam int MA_W   = D_W;
  localparam int MB_W   = SUM_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int W_W    = P_W + 1;

  localparam int SLOPE_SH = 16;
  localparam int ICPT_SH  = 8;
  localparam int NUM_W    = W_W + ICPT_SH;
  localparam int DEN_W    = P_W;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NXX,
    OP_XX,
    OP_NXY,
    OP_XY,
    OP_YSXX,
    OP_XSXY,
    OP_NSXX,
    OP_SLOPE,
    OP_ICPT
  } op_t;

  typedef struct packed {
    logic take;
    logic mul_start;
    logic div_start;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic ovf;
    logic sxx_nonpos;
  } sts_t;

  function automatic logic [OUT_W-1:0] sat_q(input logic neg, input logic [NUM_W-1:0] mag);
    logic [OUT_W-1:0] lo;
    lo = mag[OUT_W-1:0];
    if (!neg) begin
      if (|mag[NUM_W-1:OUT_W-1]) begin
        return {1'b0, {(OUT_W-1){1'b1}}};
      end
      return lo;
    end
    if ((|mag[NUM_W-1:OUT_W]) || (mag[OUT_W-1] && (|mag[OUT_W-2:0]))) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return (~lo) + OUT_W'(1);
  endfunction

endpackage

[hdl/slr_mul.sv]
// Shift-add signed multiplier, one bit of the narrow operand per cycle.
`timescale 1ns / 1ps

module slr_mul import slr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic                   done,
  output logic signed [P_W-1:0]  prod
);

  localparam int MCW = $clog2(MB_W + 1);

  logic            busy_r;
  logic            sgn_r;
  logic            done_r;
  logic [MCW-1:0]  cnt_r;
  logic [P_W-1:0]  am_r;
  logic [MB_W-1:0] bm_r;
  logic [P_W-1:0]  acc_r;
  logic            neg_r;
  logic [P_W-1:0]  prod_r;
  logic [MA_W-1:0] a_mag;
  logic [MB_W-1:0] b_mag;

  always_comb begin
    a_mag = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
    b_mag = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sgn_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MCW'(MB_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MCW'(1);
        if (cnt_r == MCW'(1)) begin
          busy_r <= 1'b0;
          sgn_r  <= 1'b1;
        end
      end else if (sgn_r) begin
        sgn_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r  <= P_W'(a_mag);
      bm_r  <= b_mag;
      acc_r <= '0;
      neg_r <= a[MA_W-1] ^ b[MB_W-1];
    end else if (busy_r) begin
      if (bm_r[0]) begin
        acc_r <= acc_r + am_r;
      end
      am_r <= {am_r[P_W-2:0], 1'b0};
      bm_r <= {1'b0, bm_r[MB_W-1:1]};
    end else if (sgn_r) begin
      prod_r <= neg_r ? (~acc_r) + P_W'(1) : acc_r;
    end
  end

  assign done = done_r;
  assign prod = $signed(prod_r);

endmodule

[hdl/slr_div.sv]
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps

module slr_div import slr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int DCW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [DCW-1:0]   cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCW'(1);
        if (cnt_r == DCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hdl/slr_dp.sv]
// Datapath: sample accumulators, operand selection, shared multiplier and divider, result registers.
`timescale 1ns / 1ps

module slr_dp import slr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic signed [IN_W-1:0] in_x_sample,
  input  logic signed [IN_W-1:0] in_y_sample,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic [OUT_W-1:0]       out_slope,
  output logic [OUT_W-1:0]       out_intercept,
  output logic [ST_W-1:0]        out_status
);

  logic                     stg_v_r;
  logic signed [IN_W-1:0]   stg_x_r;
  logic signed [IN_W-1:0]   stg_y_r;
  logic signed [PRD_W-1:0]  stg_xy_r;
  logic signed [PRD_W-1:0]  stg_xx_r;
  logic signed [PRD_W-1:0]  xy_c;
  logic signed [PRD_W-1:0]  xx_c;

  logic [CNT_W-1:0]         n_r;
  logic signed [SUM_W-1:0]  sx_r;
  logic signed [SUM_W-1:0]  sy_r;
  logic signed [PSUM_W-1:0] sxy_r;
  logic signed [PSUM_W-1:0] sxx_r;
  logic                     ovf_r;

  logic signed [D_W-1:0]    p1_r;
  logic signed [D_W-1:0]    sxx_d_r;
  logic signed [D_W-1:0]    sxy_d_r;
  logic signed [W_W-1:0]    w_r;
  logic [DEN_W-1:0]         dden_r;
  logic [OUT_W-1:0]         slope_r;
  logic [OUT_W-1:0]         icpt_r;

  logic [OUT_W-1:0]         out_slope_r;
  logic [OUT_W-1:0]         out_icpt_r;
  status_t                  out_status_r;
  status_t                  st_c;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     mul_done;
  logic signed [P_W-1:0]    mul_prod;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quo;

  logic [D_W-1:0]           sxy_mag;
  logic [W_W-1:0]           w_mag;
  logic                     sxx_nonpos;

  assign xy_c = in_x_sample * in_y_sample;
  assign xx_c = in_x_sample * in_x_sample;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      stg_x_r  <= in_x_sample;
      stg_y_r  <= in_y_sample;
      stg_xy_r <= xy_c;
      stg_xx_r <= xx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      n_r     <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      sxx_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      stg_v_r <= cmd.take;
      if (cmd.out_load) begin
        n_r   <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxy_r <= '0;
        sxx_r <= '0;
        ovf_r <= 1'b0;
      end else if (stg_v_r) begin
        if (n_r < CNT_W'(MAX_SAMPLES)) begin
          n_r   <= n_r + CNT_W'(1);
          sx_r  <= sx_r + SUM_W'(stg_x_r);
          sy_r  <= sy_r + SUM_W'(stg_y_r);
          sxy_r <= sxy_r + PSUM_W'(stg_xy_r);
          sxx_r <= sxx_r + PSUM_W'(stg_xx_r);
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sxy_mag    = sxy_d_r[D_W-1] ? D_W'(-sxy_d_r) : D_W'(sxy_d_r);
    w_mag      = w_r[W_W-1] ? W_W'(-w_r) : W_W'(w_r);
    sxx_nonpos = sxx_d_r[D_W-1] || (sxx_d_r == '0);
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    case (cmd.op)
      OP_NXX: begin
        mul_a = MA_W'(sxx_r);
        mul_b = MB_W'(n_r);
      end
      OP_XX: begin
        mul_a = MA_W'(sx_r);
        mul_b = sx_r;
      end
      OP_NXY: begin
        mul_a = MA_W'(sxy_r);
        mul_b = MB_W'(n_r);
      end
      OP_XY: begin
        mul_a = MA_W'(sy_r);
        mul_b = sx_r;
      end
      OP_YSXX: begin
        mul_a = sxx_d_r;
        mul_b = sy_r;
      end
      OP_XSXY: begin
        mul_a = sxy_d_r;
        mul_b = sx_r;
      end
      OP_NSXX: begin
        mul_a = sxx_d_r;
        mul_b = MB_W'(n_r);
      end
      OP_SLOPE: begin
        div_num = NUM_W'(sxy_mag) << SLOPE_SH;
        div_den = DEN_W'($unsigned(sxx_d_r));
      end
      OP_ICPT: begin
        div_num = NUM_W'(w_mag) << ICPT_SH;
        div_den = dden_r;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  slr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  slr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.op)
        OP_NXX, OP_NXY: p1_r    <= D_W'(mul_prod);
        OP_XX:          sxx_d_r <= p1_r - D_W'(mul_prod);
        OP_XY:          sxy_d_r <= p1_r - D_W'(mul_prod);
        OP_YSXX:        w_r     <= W_W'(mul_prod);
        OP_XSXY:        w_r     <= w_r - W_W'(mul_prod);
        OP_NSXX:        dden_r  <= $unsigned(mul_prod);
        default:        p1_r    <= p1_r;
      endcase
    end
    if (div_done) begin
      case (cmd.op)
        OP_SLOPE: slope_r <= sat_q(sxy_d_r[D_W-1], div_quo);
        OP_ICPT:  icpt_r  <= sat_q(w_r[W_W-1], div_quo);
        default:  slope_r <= slope_r;
      endcase
    end
  end

  always_comb begin
    if (ovf_r) begin
      st_c = ST_TOO_MANY;
    end else if (sxx_nonpos) begin
      st_c = ST_ZERO_VAR;
    end else begin
      st_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= st_c;
      out_slope_r  <= (st_c == ST_OK) ? slope_r : '0;
      out_icpt_r   <= (st_c == ST_OK) ? icpt_r : '0;
    end
  end

  assign sts.mul_done   = mul_done;
  assign sts.div_done   = div_done;
  assign sts.ovf        = ovf_r;
  assign sts.sxx_nonpos = sxx_nonpos;

  assign out_slope     = out_slope_r;
  assign out_intercept = out_icpt_r;
  assign out_status    = out_status_r;

endmodule

[hdl/slr_ctrl.sv]
// Controller: sample intake, sequencing of the fit arithmetic and the result register handshake.
`timescale 1ns / 1ps

module slr_ctrl import slr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_pair,
  input  logic out_ready,
  input  sts_t sts,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_ACC,
    S_DRAIN,
    S_GO,
    S_WAIT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_div;

  function automatic op_t next_op(input op_t op);
    case (op)
      OP_NXX:  return OP_XX;
      OP_XX:   return OP_NXY;
      OP_NXY:  return OP_XY;
      OP_XY:   return OP_YSXX;
      OP_YSXX: return OP_XSXY;
      OP_XSXY: return OP_NSXX;
      OP_NSXX: return OP_SLOPE;
      OP_SLOPE: return OP_ICPT;
      default: return OP_NXX;
    endcase
  endfunction

  always_comb begin
    is_div        = op_r inside {OP_SLOPE, OP_ICPT};
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      S_ACC: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_last_pair) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        op_nxt    = OP_NXX;
        state_nxt = S_GO;
      end
      S_GO: begin
        if ((op_r == OP_NXX && sts.ovf) || (op_r == OP_YSXX && sts.sxx_nonpos)) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_start = !is_div;
          cmd.div_start = is_div;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if ((is_div && sts.div_done) || (!is_div && sts.mul_done)) begin
          if (op_r == OP_ICPT) begin
            state_nxt = S_FIN;
          end else begin
            op_nxt    = next_op(op_r);
            state_nxt = S_GO;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      op_r        <= OP_NXX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/simple_linear_regression.sv]
// Top level of the one-pass least squares line fit over Q8.8 sample pairs.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_x_sample, in_y_sample, in_last_pair
//   out      output     out_valid / out_ready  out_slope, out_intercept, out_status
//
// Sample pairs are taken one beat per cycle while accumulating; each is summed in the
// cycle after it is taken. After the last pair, the fit runs seven products on a shared
// shift-add multiplier and two quotients on a shared 96-step restoring divider.
// Overflow skips the arithmetic; zero x variance is found after the first four
// products. Reset is synchronous, active low.
// A result waits in the output register while the next data set streams in; a finished
// fit holds off new samples only until the output register is free.
`timescale 1ns / 1ps

module simple_linear_regression import slr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IN_W-1:0] in_x_sample,
  input  logic signed [IN_W-1:0] in_y_sample,
  input  logic                   in_last_pair,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       out_slope,
  output logic [OUT_W-1:0]       out_intercept,
  output logic [ST_W-1:0]        out_status
);

  cmd_t cmd;
  sts_t sts;

  slr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_pair (in_last_pair),
    .out_ready    (out_ready),
    .sts          (sts),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  slr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_x_sample   (in_x_sample),
    .in_y_sample   (in_y_sample),
    .cmd           (cmd),
    .sts           (sts),
    .out_slope     (out_slope),
    .out_intercept (out_intercept),
    .out_status    (out_status)
  );

  a_no_intake_while_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> !in_ready)
    else $error("multiplier finished while samples were being taken");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over one not yet taken");

  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_pair) |=> !in_ready)
    else $error("samples taken after the last pair beat");

  a_overflow_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && sts.ovf) |=> (out_status == ST_TOO_MANY))
    else $error("sample overflow not reported");

  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_slope == '0 && out_intercept == '0))
    else $error("flagged result carries nonzero fit");

endmodule
